// File: rtl/tns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants for the trackball nibble serializer.
// ----------------------------------------------------------------------------
package tns_pkg;

	// item kinds carried in the input tuser
	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	localparam int unsigned AXIS_W    = 8;
	localparam int unsigned NIBBLE_W  = 4;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned RESULT_W  = 6;
	localparam int unsigned SELECT_BIT = 6;

	localparam logic [AXIS_W-1:0]    BASE_RESET    = 8'h80;
	localparam logic [NIBBLE_W-1:0]  NIBBLE_RESET  = 4'hf;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd143;

	// one input item after the input register
	typedef struct packed {
		logic [1:0]        func;
		logic [AXIS_W-1:0] write_data;
		logic [AXIS_W-1:0] axis_x;
		logic [AXIS_W-1:0] axis_y;
		logic              button_left_n;
		logic              button_right_n;
	} item_t;

endpackage

// File: rtl/tns_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_core
// Serializer state: select level, axis phase, samples, bases, timeout.
// Applies one item per fire and forms the read result from current state.
// ----------------------------------------------------------------------------
module tns_core
	import tns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  item_t                item,
	input  logic [TIMEOUT_W-1:0] timeout_ticks,
	output logic [RESULT_W-1:0]  read_data
);

	logic                 select_level_q;
	logic                 axis_phase_q;
	logic [NIBBLE_W-1:0]  out_nibble_q;
	logic [AXIS_W-1:0]    base_x_q, base_y_q;
	logic [AXIS_W-1:0]    sample_x_q, sample_y_q;
	logic [TIMEOUT_W-1:0] timeout_count_q;
	logic                 timeout_armed_q;

	logic                 level;
	logic                 is_write, is_tick;
	logic                 fall_edge, rise_edge;
	logic [AXIS_W-1:0]    new_sample, cur_sample, cur_base;
	logic [AXIS_W-1:0]    fall_delta, rise_delta;
	logic                 expire;

	// decode
	assign level     = item.write_data[SELECT_BIT];
	assign is_write  = fire && (func_t'(item.func) == FUNC_WRITE);
	assign is_tick   = fire && (func_t'(item.func) == FUNC_TICK);
	assign fall_edge = is_write && select_level_q && !level;
	assign rise_edge = is_write && !select_level_q && level;
	assign expire    = timeout_count_q <= TIMEOUT_W'(1);

	// axis selected by phase
	assign new_sample = axis_phase_q ? item.axis_y : item.axis_x;
	assign cur_sample = axis_phase_q ? sample_y_q : sample_x_q;
	assign cur_base   = axis_phase_q ? base_y_q : base_x_q;
	assign fall_delta = new_sample - cur_base;
	assign rise_delta = cur_sample - cur_base;

	// read result: buttons over the current nibble
	assign read_data = {item.button_right_n, item.button_left_n, out_nibble_q};

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_level_q  <= 1'b1;
			axis_phase_q    <= 1'b0;
			out_nibble_q    <= NIBBLE_RESET;
			base_x_q        <= BASE_RESET;
			base_y_q        <= BASE_RESET;
			sample_x_q      <= '0;
			sample_y_q      <= '0;
			timeout_count_q <= '0;
			timeout_armed_q <= 1'b0;
		end else begin
			if (is_write) begin
				select_level_q <= level;
			end
			if (fall_edge) begin
				timeout_armed_q <= 1'b0;
				timeout_count_q <= '0;
				if (axis_phase_q) begin
					sample_y_q <= new_sample;
				end else begin
					sample_x_q <= new_sample;
				end
				out_nibble_q <= fall_delta[AXIS_W-1 -: NIBBLE_W];
			end else if (rise_edge) begin
				timeout_armed_q <= 1'b1;
				timeout_count_q <= timeout_ticks;
				out_nibble_q    <= rise_delta[NIBBLE_W-1:0];
				if (axis_phase_q) begin
					base_x_q <= sample_x_q;
					base_y_q <= sample_y_q;
				end
				axis_phase_q <= !axis_phase_q;
			end else if (is_tick && timeout_armed_q) begin
				// count down; expiry returns to the X axis
				if (expire) begin
					timeout_count_q <= '0;
					timeout_armed_q <= 1'b0;
					axis_phase_q    <= 1'b0;
				end else begin
					timeout_count_q <= timeout_count_q - TIMEOUT_W'(1);
				end
			end
		end
	end

	// checks
	a_expire_to_x: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick && timeout_armed_q && expire |=> !axis_phase_q && !timeout_armed_q)
		else $error("timeout expiry did not return to X axis");

	a_fall_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		fall_edge |=> !timeout_armed_q && timeout_count_q == '0)
		else $error("falling edge did not disarm timeout");

	a_rise_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		rise_edge |=> timeout_armed_q && axis_phase_q != $past(axis_phase_q))
		else $error("rising edge did not arm timeout and toggle phase");

endmodule

// File: rtl/trackball_nibble_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball_nibble_serializer
// Trackball port that hands axis deltas to the host one nibble per select edge.
// ----------------------------------------------------------------------------
// One item is taken per clock. Each item is registered and is applied to the
// serializer state as it leaves the input register, where a port read also
// puts its result in the output register. Writes and ticks give no result.
// Input is stalled only when a read waits for a full output register that
// the sink is not draining. The timeout register is to be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module trackball_nibble_serializer
	import tns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,      // timeout_ticks
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] write_data, [15:8] axis_x, [23:16] axis_y,
	// [24] button_left_n, [25] button_right_n, [31:26] zero
	input  logic [31:0]          s_axis_tdata,
	input  logic [1:0]           s_axis_tuser,   // [1:0] func
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata    // [5:0] read_data, [7:6] zero
);

	logic [TIMEOUT_W-1:0] timeout_ticks_q;
	logic                 valid_s1;
	item_t                item_s1;
	logic                 out_valid_q;
	logic [RESULT_W-1:0]  out_data_q;
	logic                 out_free, is_read_s1, advance;
	logic [RESULT_W-1:0]  read_data;

	// stage 1 advances unless a read meets a blocked output register
	assign out_free      = !out_valid_q || m_axis_tready;
	assign is_read_s1    = func_t'(item_s1.func) == FUNC_READ;
	assign advance       = valid_s1 && (!is_read_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_ticks_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func           <= s_axis_tuser;
			item_s1.write_data     <= s_axis_tdata[7:0];
			item_s1.axis_x         <= s_axis_tdata[15:8];
			item_s1.axis_y         <= s_axis_tdata[23:16];
			item_s1.button_left_n  <= s_axis_tdata[24];
			item_s1.button_right_n <= s_axis_tdata[25];
		end
	end

	tns_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.item          (item_s1),
		.timeout_ticks (timeout_ticks_q),
		.read_data     (read_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_read_s1) begin
			out_data_q <= read_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};

endmodule
